// ===== rtl/core/mle_pkg.sv =====
package mle_pkg;

    localparam int MAX_LINES_DEF = 64;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
    } line_t;

endpackage

// ===== rtl/core/mle_table.sv =====
module mle_table #(
    parameter int MAX_LINES = mle_pkg::MAX_LINES_DEF,
    parameter int AW        = $clog2(MAX_LINES)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  mle_pkg::line_t  wdata,
    input  logic [AW-1:0]   raddr,
    output mle_pkg::line_t  rdata
);
    import mle_pkg::*;

    line_t mem [MAX_LINES];
    line_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mle_mul.sv =====
module mle_mul (
    input  logic               clk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod
);
    import mle_pkg::*;

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/max_line_envelope.sv =====
// Channel | Dir | tdata (lsb first)                          | tuser
// s_axis  | in  | slope[31:0] intercept[63:32] query_x[95:64] | cmd
// m_axis  | out | max_value[63:0] status[65:64] zero[71:66]   | -
//
// One transfer in, one transfer out; not ready while an item is in work.
// Query: each table entry scanned takes a memory read, a multiply and an add/compare.
// Insert: a read and compare per entry searched, a read and write per entry shifted
// on insert or removal, plus reads, multiplies and a compare per neighbor check.
// Reset clears the line count, state and output valid only; the table needs no clearing pass.
module max_line_envelope #(
    parameter int MAX_LINES = mle_pkg::MAX_LINES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // slope, intercept, query_x
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // max_value, status, pad
);
    import mle_pkg::*;

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(MAX_LINES);

    typedef enum logic [4:0] {
        S_IDLE, S_F_RD, S_F_CHK, S_SH, S_SH_WR, S_U, S_U1, S_U2, S_U3,
        S_U4, S_U5, S_U6, S_RM, S_RM_WR, S_Q_RD, S_Q_MUL, S_Q_ADD, S_DONE
    } state_t;

    typedef enum logic [1:0] {M_MID, M_LEFT, M_RIGHT} mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] u_reg, u_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next, x_reg, x_next;
    line_t p_reg, p_next, c_reg, c_next, n_reg, n_next;
    logic signed [65:0] p1_reg, p1_next;
    logic signed [63:0] prev_reg, prev_next;
    logic signed [31:0] hold_reg, hold_next;
    logic signed [63:0] res_value_reg, res_value_next;
    logic [1:0] res_status_reg, res_status_next;
    logic m_valid_reg, m_valid_next;
    logic [71:0] m_data_reg, m_data_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    line_t wdata, rdata;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic signed [63:0] val;
    logic dec, flg;

    mle_table #(.MAX_LINES(MAX_LINES), .AW(AW)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mle_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign val = prod[63:0] + 64'(hold_reg);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        u_next          = u_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        x_next          = x_reg;
        p_next          = p_reg;
        c_next          = c_reg;
        n_next          = n_reg;
        p1_next         = p1_reg;
        prev_next       = prev_reg;
        hold_next       = hold_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        op_a  = '0;
        op_b  = '0;
        dec   = 1'b0;
        flg   = 1'b0;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next          = s_axis_tdata[31:0];
                    b_next          = s_axis_tdata[63:32];
                    x_next          = s_axis_tdata[95:64];
                    idx_next        = '0;
                    res_value_next  = '0;
                    res_status_next = STATUS_OK;
                    if (s_axis_tuser == CMD_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_Q_RD;
                        end
                    end
                    else if (count_reg == FULL)
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_F_RD:
            begin
                raddr = idx_reg[AW-1:0];
                if (idx_reg == count_reg)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SH;
                end
                else
                begin
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (rdata.slope < a_reg ||
                    (rdata.slope == a_reg && rdata.intercept < b_reg))
                begin
                    idx_next   = idx_reg + ONE;
                    state_next = S_F_RD;
                end
                else if (rdata.slope == a_reg && rdata.intercept == b_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SH;
                end
            end
            S_SH:
            begin
                if (idx_reg == pos_reg)
                begin
                    we              = 1'b1;
                    waddr           = pos_reg[AW-1:0];
                    wdata.slope     = a_reg;
                    wdata.intercept = b_reg;
                    count_next      = count_reg + ONE;
                    mode_next       = M_MID;
                    u_next          = pos_reg;
                    state_next      = S_U;
                end
                else
                begin
                    raddr      = idx_reg[AW-1:0] - AW'(1);
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata;
                idx_next   = idx_reg - ONE;
                state_next = S_SH;
            end
            S_U:
            begin
                if (u_reg == '0 || ({1'b0, u_reg} + (CW+1)'(1)) >= {1'b0, count_reg})
                begin
                    dec = 1'b1;
                end
                else
                begin
                    raddr      = u_reg[AW-1:0] - AW'(1);
                    state_next = S_U1;
                end
            end
            S_U1:
            begin
                p_next     = rdata;
                raddr      = u_reg[AW-1:0];
                state_next = S_U2;
            end
            S_U2:
            begin
                c_next     = rdata;
                raddr      = u_reg[AW-1:0] + AW'(1);
                state_next = S_U3;
            end
            S_U3:
            begin
                n_next     = rdata;
                state_next = S_U4;
            end
            S_U4:
            begin
                op_a       = 33'(c_reg.intercept) - 33'(p_reg.intercept);
                op_b       = 33'(n_reg.slope) - 33'(c_reg.slope);
                state_next = S_U5;
            end
            S_U5:
            begin
                p1_next    = prod;
                op_a       = 33'(c_reg.intercept) - 33'(n_reg.intercept);
                op_b       = 33'(p_reg.slope) - 33'(c_reg.slope);
                state_next = S_U6;
            end
            S_U6:
            begin
                dec = 1'b1;
                flg = (p1_reg <= prod);
            end
            S_RM:
            begin
                raddr = idx_reg[AW-1:0] + AW'(1);
                if (({1'b0, idx_reg} + (CW+1)'(1)) >= {1'b0, count_reg})
                begin
                    count_next = count_reg - ONE;
                    unique case (mode_reg)
                        M_LEFT:
                        begin
                            pos_next   = pos_reg - ONE;
                            state_next = S_U;
                            if (pos_reg == ONE)
                            begin
                                mode_next = M_RIGHT;
                                u_next    = ONE;
                            end
                            else
                            begin
                                u_next = pos_reg - CW'(2);
                            end
                        end
                        M_RIGHT:
                        begin
                            u_next     = pos_reg + ONE;
                            state_next = S_U;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata;
                idx_next   = idx_reg + ONE;
                state_next = S_RM;
            end
            S_Q_RD:
            begin
                raddr      = idx_reg[AW-1:0];
                state_next = S_Q_MUL;
            end
            S_Q_MUL:
            begin
                op_a       = 33'(rdata.slope);
                op_b       = 33'(x_reg);
                hold_next  = rdata.intercept;
                state_next = S_Q_ADD;
            end
            S_Q_ADD:
            begin
                if (idx_reg != '0 && prev_reg > val)
                begin
                    res_value_next = prev_reg;
                    state_next     = S_DONE;
                end
                else if (idx_reg + ONE == count_reg)
                begin
                    res_value_next = val;
                    state_next     = S_DONE;
                end
                else
                begin
                    prev_next  = val;
                    idx_next   = idx_reg + ONE;
                    state_next = S_Q_RD;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, res_status_reg, res_value_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // neighbor check outcome
        if (dec)
        begin
            unique case (mode_reg)
                M_MID:
                begin
                    if (flg)
                    begin
                        idx_next   = pos_reg;
                        state_next = S_RM;
                    end
                    else if (pos_reg == '0)
                    begin
                        mode_next  = M_RIGHT;
                        u_next     = pos_reg + ONE;
                        state_next = S_U;
                    end
                    else
                    begin
                        mode_next  = M_LEFT;
                        u_next     = pos_reg - ONE;
                        state_next = S_U;
                    end
                end
                M_LEFT:
                begin
                    if (flg)
                    begin
                        idx_next   = pos_reg - ONE;
                        state_next = S_RM;
                    end
                    else
                    begin
                        mode_next  = M_RIGHT;
                        u_next     = pos_reg + ONE;
                        state_next = S_U;
                    end
                end
                default:
                begin
                    if (flg)
                    begin
                        idx_next   = pos_reg + ONE;
                        state_next = S_RM;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= M_MID;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        u_reg          <= u_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        x_reg          <= x_next;
        p_reg          <= p_next;
        c_reg          <= c_next;
        n_reg          <= n_next;
        p1_reg         <= p1_next;
        prev_reg       <= prev_next;
        hold_reg       <= hold_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== bench/tb_max_line_envelope.sv =====
`timescale 1ns / 1ps

module tb_max_line_envelope;
    import mle_pkg::*;

    localparam int DEPTH = MAX_LINES_DEF;
    localparam int STALL_LIMIT = 100000;

    typedef struct {
        logic signed [63:0] max_value;
        logic [1:0]         status;
    } envelope_result_t;

    class envelope_scoreboard;
        logic signed [63:0] slopes[DEPTH];
        logic signed [63:0] icepts[DEPTH];
        int count;
        envelope_result_t pending[$];
        int errors;

        function void clear();
            count = 0;
            errors = 0;
            pending.delete();
        endfunction

        function automatic logic signed [63:0] line_val(int i, logic signed [63:0] x);
            return slopes[i] * x + icepts[i];
        endfunction

        // cross-product test at 128 bits, no overflow possible
        function automatic bit redundant(int i);
            logic signed [127:0] lhs, rhs;
            if (i == 0 || i + 1 >= count)
                return 0;
            lhs = 128'(icepts[i] - icepts[i-1]) * 128'(slopes[i+1] - slopes[i]);
            rhs = 128'(icepts[i] - icepts[i+1]) * 128'(slopes[i-1] - slopes[i]);
            return lhs <= rhs;
        endfunction

        function void drop(int i);
            for (int k = i; k < count - 1; k++)
            begin
                slopes[k] = slopes[k+1];
                icepts[k] = icepts[k+1];
            end
            count--;
        endfunction

        function automatic logic [1:0] add_line(logic signed [63:0] a, logic signed [63:0] b);
            int pos;
            pos = 0;
            if (count >= DEPTH)
                return STATUS_FULL;
            while (pos < count && (slopes[pos] < a || (slopes[pos] == a && icepts[pos] < b)))
                pos++;
            if (pos < count && slopes[pos] == a && icepts[pos] == b)
                return STATUS_OK;
            for (int k = count; k > pos; k--)
            begin
                slopes[k] = slopes[k-1];
                icepts[k] = icepts[k-1];
            end
            slopes[pos] = a;
            icepts[pos] = b;
            count++;
            if (redundant(pos))
            begin
                drop(pos);
                return STATUS_OK;
            end
            while (pos > 0 && redundant(pos - 1))
            begin
                drop(pos - 1);
                pos--;
            end
            while (pos + 1 < count && redundant(pos + 1))
                drop(pos + 1);
            return STATUS_OK;
        endfunction

        function void note_input(logic cmd, logic [95:0] data);
            envelope_result_t r;
            logic signed [63:0] x;
            int i;
            r.max_value = 0;
            r.status = STATUS_OK;
            if (cmd == CMD_INSERT)
                r.status = add_line(64'(signed'(data[31:0])), 64'(signed'(data[63:32])));
            else if (count == 0)
                r.status = STATUS_EMPTY;
            else
            begin
                x = 64'(signed'(data[95:64]));
                i = 0;
                while (i + 1 < count && !(line_val(i, x) > line_val(i + 1, x)))
                    i++;
                r.max_value = line_val(i, x);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [71:0] data);
            envelope_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $realtime, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[63:0] !== e.max_value)
            begin
                $display("%0t: max_value expected %0d actual %0d", $realtime,
                         e.max_value, $signed(data[63:0]));
                errors++;
            end
            if (data[65:64] !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime,
                         e.status, data[65:64]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    envelope_scoreboard sb;
    int  idle_pct;
    int  accepted;
    int  quiet_cycles;
    bit  timed_out;

    max_line_envelope u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // sink side with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("tb_max_line_envelope: done, errors");
            $finish;
        end
    end

    task automatic send_item(logic cmd, logic [31:0] a, logic [31:0] b, logic [31:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {x, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(cmd, {x, b, a});
        accepted++;
    endtask

    function automatic logic [31:0] pick_value(int mode);
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(mode == 0 ? $urandom_range(10) : $urandom_range(1000));
            3: return -32'($urandom_range(1000));
            default: return $urandom;
        endcase
    endfunction

    task automatic insert_line(logic [31:0] a, logic [31:0] b);
        send_item(CMD_INSERT, a, b, $urandom);
    endtask

    task automatic query_at(logic [31:0] x);
        send_item(CMD_QUERY, $urandom, $urandom, x);
    endtask

    initial
    begin
        int n;
        sb = new();
        sb.clear();
        idle_pct = 14;
        accepted = 0;
        quiet_cycles = 0;
        timed_out = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_INSERT;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        query_at(32'h0000_0005);
        insert_line(32'h7fff_ffff, 32'h8000_0000);
        insert_line(32'h7fff_ffff, 32'h8000_0000);
        insert_line(32'h8000_0000, 32'h7fff_ffff);
        query_at(32'h8000_0000);
        query_at(32'h7fff_ffff);
        query_at(32'h0);
        insert_line(32'h0, 32'h8000_0000);
        insert_line(32'h0, 32'h0);
        insert_line(32'h0, 32'h7fff_ffff);
        insert_line(32'h0, 32'h7fff_ffff);
        insert_line(32'h1, 32'h1);
        insert_line(32'hffff_ffff, 32'hffff_ffff);
        query_at(32'h1);
        query_at(32'hffff_ffff);
        query_at(32'hffff_ffff);

        // fill table with non-dominated parabola tangents, then overflow
        for (int i = 0; i < DEPTH + 4; i++)
            insert_line(32'(2 * i - 200), -32'((i - 100) * (i - 100)));
        for (int i = 0; i < 6; i++)
            query_at(pick_value(1));

        // random: tangent sets reach deep, noise mixed in
        n = 0;
        idle_pct = 14;
        while (n < 1150)
        begin
            if (n >= 300 && n < 500)
                idle_pct = 0;
            else
                idle_pct = 14;
            if ($urandom_range(99) < 12)
            begin
                // wide-range extremes on a fresh table view
                if ($urandom_range(1))
                    insert_line(pick_value(1), pick_value(1));
                else
                    query_at(pick_value(1));
                n++;
            end
            else if ($urandom_range(99) < 50)
            begin
                int k;
                k = int'($urandom_range(600)) - 300;
                insert_line(32'(k * int'($urandom_range(4, 1))),
                            -32'(k * k) + $urandom_range(3));
                n++;
            end
            else
            begin
                query_at($urandom_range(1) ? 32'(int'($urandom_range(800)) - 400) : $urandom);
                n++;
            end
        end
        s_axis_tvalid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_max_line_envelope: done, clean");
        else
            $display("tb_max_line_envelope: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/mle_pkg.sv
rtl/core/mle_table.sv
rtl/core/mle_mul.sv
rtl/core/max_line_envelope.sv
bench/tb_max_line_envelope.sv
